[rtl/core/assert_macros.svh]
// assertion macros shared by the deque rtl
// no dependencies; taken in by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DEQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("deque check failed");

// when pre holds, post must hold in the next cycle
`define DEQ_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("deque check failed");

`endif

[rtl/core/deq_pkg.sv]
// shared types and codes for the deque unit
// no dependencies; used by every module of the block
`default_nettype none

package deq_pkg;

  // operation codes on the op port
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  // classified command kinds carried to the back end
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_READ       = 3'd4;
  localparam logic [2:0] KIND_CLEAR      = 3'd5;
  localparam logic [2:0] KIND_NOP        = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // result queue sizing
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;
  localparam int OUT_LW    = 3;

  typedef logic [OUT_LW-1:0] out_lvl_t;
  typedef logic [OUT_AW-1:0] out_ptr_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [8:0]  position;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic [8:0]  count;
    logic [1:0]  status;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/deq_front.sv]
// front end: accepts operation beats, classifies them, holds them in a
// two-entry command queue; depends on deq_pkg
`default_nettype none

module deq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [2:0]        op,
  input  wire logic [31:0]       push_value,
  input  wire logic [8:0]        position,
  output logic                   cmd_valid,
  input  wire logic              cmd_take,
  output deq_pkg::cmd_t          cmd
);

  deq_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    level;
  logic          accept;
  logic [2:0]    kind;

  assign full      = (level == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (level != 2'd0);
  assign cmd       = q[rd_ptr];

  // map op codes to command kinds, unused codes become no-ops
  always_comb begin
    unique case (op)
      deq_pkg::OP_PUSH_FRONT: kind = deq_pkg::KIND_PUSH_FRONT;
      deq_pkg::OP_PUSH_BACK:  kind = deq_pkg::KIND_PUSH_BACK;
      deq_pkg::OP_POP_FRONT:  kind = deq_pkg::KIND_POP_FRONT;
      deq_pkg::OP_POP_BACK:   kind = deq_pkg::KIND_POP_BACK;
      deq_pkg::OP_READ:       kind = deq_pkg::KIND_READ;
      deq_pkg::OP_CLEAR:      kind = deq_pkg::KIND_CLEAR;
      default:                kind = deq_pkg::KIND_NOP;
    endcase
  end

  // command queue payload
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= '{kind: kind, value: push_value, position: position};
    end
  end

  // command queue pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      level <= level + 2'(accept) - 2'(cmd_take);
    end
  end

endmodule

`default_nettype wire

[rtl/core/deq_back.sv]
// back end: ring store, front pointer and occupancy; one command per cycle while
// output has room, registered store read; depends on deq_pkg, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module deq_back #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire deq_pkg::cmd_t     cmd,
  output logic                   cmd_take,
  input  wire deq_pkg::out_lvl_t out_level,
  output logic                   res_valid,
  output deq_pkg::res_t          res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int MW = (CW > 9) ? CW : 9;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         front;
  logic [CW-1:0]         occ;
  logic [AW-1:0]         front_next;
  logic [CW-1:0]         occ_next;

  logic                  we;
  logic                  re;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [1:0]            status;

  logic                  is_full;
  logic                  is_empty;
  logic                  pos_ok;
  logic [AW-1:0]         front_dec;
  logic [AW-1:0]         front_inc;
  logic [AW-1:0]         back_idx;
  logic [AW-1:0]         last_idx;
  logic [AW-1:0]         read_idx;
  logic [deq_pkg::OUT_LW:0] credit_use;

  // stage after issue
  logic                  s_valid;
  logic                  s_has_data;
  logic [8:0]            s_count;
  logic [1:0]            s_status;
  logic [DATA_WIDTH-1:0] rdata;
  logic signed [DATA_WIDTH-1:0] rdata_s;

  // fold a sum below twice the depth back into the ring
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] w;
    w = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return w[AW-1:0];
  endfunction

  // issue only while the result queue has room for everything in flight
  assign credit_use = (deq_pkg::OUT_LW + 1)'(out_level) + (deq_pkg::OUT_LW + 1)'(s_valid);
  assign cmd_take   = cmd_valid && (credit_use < (deq_pkg::OUT_LW + 1)'(deq_pkg::OUT_DEPTH));

  // ring positions
  assign is_full   = (occ == CW'(DEPTH));
  assign is_empty  = (occ == '0);
  assign pos_ok    = (cmd.position != 9'd0) && (MW'(cmd.position) <= MW'(occ));
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = wrap(SW'(front) + SW'(1));
  assign back_idx  = wrap(SW'(front) + SW'(occ));
  assign last_idx  = wrap(SW'(front) + SW'(occ) - SW'(1));
  assign read_idx  = wrap(SW'(front) + SW'(cmd.position) - SW'(1));
  assign wdata     = DATA_WIDTH'($signed(cmd.value));

  // command execution
  always_comb begin
    front_next = front;
    occ_next   = occ;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = back_idx;
    raddr      = front;
    status     = deq_pkg::ST_OK;
    unique case (cmd.kind)
      deq_pkg::KIND_PUSH_FRONT: begin
        if (is_full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          front_next = front_dec;
          waddr      = front_dec;
          we         = 1'b1;
          occ_next   = occ + CW'(1);
        end
      end
      deq_pkg::KIND_PUSH_BACK: begin
        if (is_full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          we       = 1'b1;
          occ_next = occ + CW'(1);
        end
      end
      deq_pkg::KIND_POP_FRONT: begin
        if (is_empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          re         = 1'b1;
          front_next = front_inc;
          occ_next   = occ - CW'(1);
        end
      end
      deq_pkg::KIND_POP_BACK: begin
        if (is_empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          re       = 1'b1;
          raddr    = last_idx;
          occ_next = occ - CW'(1);
        end
      end
      deq_pkg::KIND_READ: begin
        if (!pos_ok) begin
          status = deq_pkg::ST_RANGE;
        end else begin
          re    = 1'b1;
          raddr = read_idx;
        end
      end
      deq_pkg::KIND_CLEAR: begin
        occ_next = '0;
      end
      default: begin
      end
    endcase
  end

  // ring store, registered read
  always_ff @(posedge clk) begin
    if (cmd_take && we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_take && re) begin
      rdata <= mem[raddr];
    end
  end

  // pointer, occupancy and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      front   <= '0;
      occ     <= '0;
      s_valid <= 1'b0;
    end else begin
      s_valid <= cmd_take;
      if (cmd_take) begin
        front <= front_next;
        occ   <= occ_next;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s_has_data <= re;
      s_count    <= 9'(occ_next);
      s_status   <= status;
    end
  end

  // result beat, value sign-extended from the stored width
  assign rdata_s   = $signed(rdata);
  assign res_valid = s_valid;
  assign res.value  = s_has_data ? 32'(rdata_s) : 32'd0;
  assign res.count  = s_count;
  assign res.status = s_status;

  `DEQ_ASSERT(a_occ_bound, clk, rst, occ <= CW'(DEPTH))
  `DEQ_ASSERT_NEXT(a_pop_front_dec, clk, rst,
    cmd_take && (cmd.kind == deq_pkg::KIND_POP_FRONT) && !is_empty,
    (occ == $past(occ) - CW'(1)) && (front == $past(front_inc)))

endmodule

`default_nettype wire

[rtl/core/deq_out_fifo.sv]
// result queue: four-entry buffer between the back end and the result port
// depends on deq_pkg, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module deq_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire deq_pkg::res_t     in_res,
  output deq_pkg::out_lvl_t      level,
  output logic                   empty,
  input  wire logic              pop,
  output deq_pkg::res_t          head
);

  deq_pkg::res_t     q [deq_pkg::OUT_DEPTH];
  deq_pkg::out_ptr_t wr_ptr;
  deq_pkg::out_ptr_t rd_ptr;
  logic              take;

  assign empty = (level == '0);
  assign take  = pop && !empty;
  assign head  = q[rd_ptr];

  // payload
  always_ff @(posedge clk) begin
    if (in_valid) begin
      q[wr_ptr] <= in_res;
    end
  end

  // pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (in_valid) begin
        wr_ptr <= wr_ptr + deq_pkg::out_ptr_t'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + deq_pkg::out_ptr_t'(1);
      end
      level <= level + deq_pkg::out_lvl_t'(in_valid) - deq_pkg::out_lvl_t'(take);
    end
  end

  `DEQ_ASSERT(a_level_bound, clk, rst, level <= deq_pkg::out_lvl_t'(deq_pkg::OUT_DEPTH))
  `DEQ_ASSERT(a_no_overflow, clk, rst,
    !in_valid || (level < deq_pkg::out_lvl_t'(deq_pkg::OUT_DEPTH)) || take)

endmodule

`default_nettype wire

[rtl/core/double_ended_queue_unit.sv]
// path: an accepted operation passes the command queue, the registered store
//   read and the result queue before its result beat is shown at the port
// throughput: one operation per cycle while the result queue has room; each op
//   updates pointer and occupancy, reads the store through one registered port
// reset: pointer, occupancy and all queues cleared at once; the ring store is
//   not cleared, so the block takes operations from the first cycle after reset
`default_nettype none

module double_ended_queue_unit #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] push_value,
  input  wire logic [8:0]  position,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      result_value,
  output logic [8:0]       entry_count,
  output logic [1:0]       status
);

  logic              cmd_valid;
  logic              cmd_take;
  deq_pkg::cmd_t     cmd;
  deq_pkg::out_lvl_t out_level;
  logic              res_valid;
  deq_pkg::res_t     res;
  deq_pkg::res_t     head;

  // accept and classify
  deq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .push_value (push_value),
    .position   (position),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .cmd        (cmd)
  );

  // execute against the ring
  deq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_level (out_level),
    .res_valid (res_valid),
    .res       (res)
  );

  // buffer results for the consumer
  deq_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_res   (res),
    .level    (out_level),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign result_value = head.value;
  assign entry_count  = head.count;
  assign status       = head.status;

endmodule

`default_nettype wire

[dv/tb_double_ended_queue_unit.sv]
// self-checking testbench for double_ended_queue_unit: directed and random ops against a shadow deque
// depends on deq_pkg (op and status codes, res_t) and the double_ended_queue_unit rtl
module tb_double_ended_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH   = 256;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  // op codes the block must treat as no-ops
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_READ} traffic_mode_t;
  typedef enum int {POP_STEADY, POP_COIN, POP_SPARSE, POP_WAVE} pop_pattern_t;

  // shadow deque and the results it expects, oldest first
  class deque_shadow_t;
    logic [31:0]   ring [RING_DEPTH];
    logic [7:0]    head = '0;
    logic [8:0]    fill = '0;
    deq_pkg::res_t expected_results[$];
    int            errors = 0;

    // apply one accepted op and queue the result it must produce
    function void note_op(logic [2:0] o, logic [31:0] v, logic [8:0] p);
      deq_pkg::res_t r;
      logic [7:0]    slot;
      r = '0;
      case (o)
        deq_pkg::OP_PUSH_FRONT: begin
          if (fill == RING_DEPTH) begin
            r.status = deq_pkg::ST_FULL;
          end else begin
            head = head - 8'd1;
            ring[head] = v;
            fill++;
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (fill == RING_DEPTH) begin
            r.status = deq_pkg::ST_FULL;
          end else begin
            slot = head + fill[7:0];
            ring[slot] = v;
            fill++;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (fill == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            r.value = ring[head];
            head = head + 8'd1;
            fill--;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (fill == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            slot = head + fill[7:0] - 8'd1;
            r.value = ring[slot];
            fill--;
          end
        end
        deq_pkg::OP_READ: begin
          if (p == 0 || p > fill) begin
            r.status = deq_pkg::ST_RANGE;
          end else begin
            slot = head + p[7:0] - 8'd1;
            r.value = ring[slot];
          end
        end
        deq_pkg::OP_CLEAR: fill = '0;
        default: ;
      endcase
      r.count = fill;
      expected_results.push_back(r);
    endfunction

    // compare one popped result beat with the oldest expectation
    function void check_result(logic [31:0] v, logic [8:0] c, logic [1:0] s);
      deq_pkg::res_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat value %h count %0d status %0d", $time, v, c, s);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (v !== e.value) begin
        $display("%0t: result_value expected %h actual %h", $time, e.value, v);
        errors++;
      end
      if (c !== e.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, e.count, c);
        errors++;
      end
      if (s !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, s);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  op = '0;
  logic [31:0] push_value = '0;
  logic [8:0]  position = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] result_value;
  logic [8:0]  entry_count;
  logic [1:0]  status;

  deque_shadow_t shadow;
  int            burst_left = 0;
  int            cycles = 0;
  pop_pattern_t  pop_pattern = POP_STEADY;
  int            pattern_left = 0;

  double_ended_queue_unit dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .push_value   (push_value),
    .position     (position),
    .empty        (empty),
    .pop          (pop),
    .result_value (result_value),
    .entry_count  (entry_count),
    .status       (status)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // drive one op beat, mostly idling between bursts, and record it once accepted
  task automatic send_beat(input logic [2:0] o, input logic [31:0] v, input logic [8:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    op <= o;
    push_value <= v;
    position <= p;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    shadow.note_op(o, v, p);
  endtask

  // pick an op weighted by the traffic mode, then a value and a position
  task automatic send_random(input traffic_mode_t mode);
    int          r;
    int          occ;
    logic [2:0]  o;
    logic [31:0] v;
    logic [8:0]  p;
    r = $urandom_range(0, 99);
    occ = shadow.fill;
    case (mode)
      MODE_FILL:
        o = (r < 45) ? deq_pkg::OP_PUSH_FRONT : (r < 90) ? deq_pkg::OP_PUSH_BACK :
            (r < 97) ? deq_pkg::OP_READ : deq_pkg::OP_POP_FRONT;
      MODE_DRAIN:
        o = (r < 45) ? deq_pkg::OP_POP_FRONT : (r < 90) ? deq_pkg::OP_POP_BACK :
            (r < 97) ? deq_pkg::OP_READ : deq_pkg::OP_PUSH_BACK;
      MODE_READ:
        o = (r < 70) ? deq_pkg::OP_READ : (r < 80) ? deq_pkg::OP_PUSH_FRONT :
            (r < 90) ? deq_pkg::OP_PUSH_BACK :
            (r < 95) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
      default: begin
        if (r < 3) o = deq_pkg::OP_CLEAR;
        else if (r < 5) o = (r == 3) ? OP_SPARE_6 : OP_SPARE_7;
        else o = 3'($urandom_range(0, 4));
      end
    endcase
    // values lean on the sign, zero and all-ones corners
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'hffff_ffff;
      3: v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    // positions mostly in range, with both borders and strays
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = 9'((occ < RING_DEPTH) ? occ + 1 : RING_DEPTH);
      2: p = 9'($urandom_range(0, RING_DEPTH));
      3: p = 9'(occ);
      default: p = 9'($urandom_range(1, (occ > 0) ? occ : 1));
    endcase
    send_beat(o, v, p);
  endtask

  // result side: check each popped beat, stall on a changing pattern
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) shadow.check_result(result_value, entry_count, status);
      if (pattern_left == 0) begin
        pop_pattern = pop_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(5, 80);
      end
      pattern_left--;
      case (pop_pattern)
        POP_STEADY: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        POP_SPARSE: pop <= ($urandom_range(0, 5) == 0);
        default:    pop <= ((pattern_left % 8) < 4);
      endcase
    end
  end

  initial begin : stimulus
    int            sent;
    int            seg;
    int            seg_len;
    traffic_mode_t mode;
    shadow = new;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pops and reads, extremes, pointer wrap, clear, spare ops
    send_beat(deq_pkg::OP_POP_FRONT, 32'h0, 9'd0);
    send_beat(deq_pkg::OP_POP_BACK, 32'h0, 9'd0);
    send_beat(deq_pkg::OP_READ, 32'h0, 9'd0);
    send_beat(deq_pkg::OP_READ, 32'h0, 9'd1);
    send_beat(deq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff, 9'd0);
    send_beat(deq_pkg::OP_PUSH_BACK, 32'h8000_0000, 9'd0);
    send_beat(deq_pkg::OP_PUSH_FRONT, 32'hffff_ffff, 9'h1ff);
    send_beat(deq_pkg::OP_PUSH_BACK, 32'h0000_0000, 9'd0);
    send_beat(deq_pkg::OP_READ, 32'h0, 9'd1);
    send_beat(deq_pkg::OP_READ, 32'h0, 9'd4);
    send_beat(deq_pkg::OP_READ, 32'h0, 9'd5);
    send_beat(deq_pkg::OP_READ, 32'h0, 9'd256);
    send_beat(deq_pkg::OP_POP_FRONT, 32'h0, 9'd0);
    send_beat(deq_pkg::OP_POP_BACK, 32'h0, 9'd0);
    send_beat(OP_SPARE_6, 32'hdead_beef, 9'd1);
    send_beat(OP_SPARE_7, 32'h1234_5678, 9'd2);
    send_beat(deq_pkg::OP_READ, 32'h0, 9'd2);
    send_beat(deq_pkg::OP_CLEAR, 32'h0, 9'd0);
    send_beat(deq_pkg::OP_POP_FRONT, 32'h0, 9'd0);
    send_beat(deq_pkg::OP_READ, 32'h0, 9'd1);
    send_beat(deq_pkg::OP_PUSH_BACK, 32'h5555_5555, 9'd0);
    send_beat(deq_pkg::OP_PUSH_FRONT, 32'haaaa_aaaa, 9'd0);
    send_beat(deq_pkg::OP_READ, 32'h0, 9'd2);
    send_beat(deq_pkg::OP_POP_BACK, 32'h0, 9'd0);
    send_beat(deq_pkg::OP_POP_FRONT, 32'h0, 9'd0);

    // random: one fill to full, one drain to empty, then mixed segments
    sent = 0;
    seg = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seg == 0) begin
        mode = MODE_FILL;
        seg_len = 360;
      end else if (seg == 1) begin
        mode = MODE_DRAIN;
        seg_len = 320;
      end else begin
        mode = traffic_mode_t'($urandom_range(0, 3));
        seg_len = $urandom_range(10, 120);
      end
      for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
        send_random(mode);
        sent++;
      end
      seg++;
    end
    push <= 1'b0;

    // wait out the remaining results, then a drain period for strays
    while (shadow.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_front.sv
rtl/core/deq_back.sv
rtl/core/deq_out_fifo.sv
rtl/core/double_ended_queue_unit.sv
dv/tb_double_ended_queue_unit.sv
